>>> hw/rtl/udp_flow_table_idle_evict_unit_assert.svh
// Assertion macros shared by the flow table RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef UDP_FLOW_TABLE_IDLE_EVICT_UNIT_ASSERT_SVH
`define UDP_FLOW_TABLE_IDLE_EVICT_UNIT_ASSERT_SVH

// Condition a in a cycle implies condition c in the same cycle.
`define UFT_ASSERT_SAME(lbl, clk, rst_n, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);

// Condition a in a cycle implies condition c in the next cycle.
`define UFT_ASSERT_NEXT(lbl, clk, rst_n, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);

`endif

>>> hw/rtl/udpfte_pkg.sv
// Types and constants of the UDP flow table.
// Used by the entry RAM wrapper users and the top level; depends on nothing.
package udpfte_pkg;

  typedef struct packed {
    logic [63:0] addr;
    logic [39:0] pp;
    logic [31:0] id;
    logic [63:0] act;
    logic [31:0] cc;
    logic [31:0] rc;
    logic        bound;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  localparam logic [2:0] OP_CLIENT  = 3'd0;
  localparam logic [2:0] OP_REMOTE  = 3'd1;
  localparam logic [2:0] OP_CLOSE   = 3'd2;
  localparam logic [2:0] OP_PURGE   = 3'd3;
  localparam logic [2:0] OP_FINDKEY = 3'd4;
  localparam logic [2:0] OP_FINDID  = 3'd5;
  localparam logic [2:0] OP_SHUT    = 3'd6;

  localparam logic [2:0] ST_ACCEPTED = 3'd0;
  localparam logic [2:0] ST_BLOCK    = 3'd1;
  localparam logic [2:0] ST_REJECTED = 3'd2;
  localparam logic [2:0] ST_NOCAP    = 3'd3;
  localparam logic [2:0] ST_IGNORED  = 3'd4;
  localparam logic [2:0] ST_NOTFOUND = 3'd5;
  localparam logic [2:0] ST_FOUND    = 3'd6;

  localparam logic [1:0] PS_WHOLE   = 2'd0;
  localparam logic [1:0] PS_PARTIAL = 2'd1;
  localparam logic [1:0] PS_BLOCK   = 2'd2;

  localparam logic [7:0] PROTO_UDP = 8'd17;

  localparam logic CFG_MAX_ENTRIES = 1'b0;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SRD,
    S_SCHK,
    S_MRD,
    S_MWR,
    S_NEW,
    S_DONE
  } state_t;

endpackage

>>> hw/rtl/udp_flow_table_idle_evict_unit.sv
// UDP flow table with idle eviction: sequencer around one entry RAM.
// Depends on udpfte_pkg, udpfte_ram and the assertion macro header.
//
// Usage: an item is transferred when start is high and busy is low. The item
// is then worked on alone; busy stays high until its single result has been
// shown. The result appears on the out_ ports for exactly one cycle, marked by
// out_valid, and cannot be held off. An ignored item or a shutdown goes
// straight to its result; a lookup reads the live entries one at a time. Each
// removal moves every later entry down by one to close the gap, and a purge
// removes every idle entry in one pass. The time taken is set by the single
// read port of the entry RAM, through which the entries are visited in turn.
// Configuration writes are taken at any time through cfg_valid/cfg_ready and
// must be made while the block is idle. Reset empties the table, clears the
// flow id counter and shutdown flag and loads the register defaults; the RAM
// needs no clearing pass because only entries below the live count are read.
`include "udp_flow_table_idle_evict_unit_assert.svh"
module udp_flow_table_idle_evict_unit #(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_opcode,
  input  logic [31:0] in_src_addr,
  input  logic [31:0] in_dst_addr,
  input  logic [15:0] in_src_port,
  input  logic [15:0] in_dst_port,
  input  logic [7:0]  in_proto_num,
  input  logic        in_families_match,
  input  logic [31:0] in_id_query,
  input  logic [63:0] in_now_ms,
  input  logic        in_open_ok,
  input  logic [1:0]  in_partner_status,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [31:0] out_flow_id,
  output logic        out_bound,
  output logic [63:0] out_last_activity,
  output logic [31:0] out_client_count,
  output logic [31:0] out_remote_count,
  output logic [31:0] out_src_addr,
  output logic [31:0] out_dst_addr,
  output logic [15:0] out_src_port,
  output logic [15:0] out_dst_port,
  output logic [7:0]  out_proto,
  output logic [4:0]  out_entry_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);
  import udpfte_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  state_t      state_r, state_nxt;
  logic [2:0]  op_r, op_nxt;
  logic [63:0] addr_r, addr_nxt;
  logic [39:0] pp_r, pp_nxt;
  logic [31:0] qid_r, qid_nxt;
  logic [63:0] now_r, now_nxt;
  logic        open_r, open_nxt;
  logic [1:0]  ps_r, ps_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] mv_r, mv_nxt;
  logic [CNT_W-1:0] live_r, live_nxt;
  logic [31:0] next_id_r, next_id_nxt;
  logic        shut_r, shut_nxt;
  logic        evict_r, evict_nxt;
  logic        rev_r, rev_nxt;
  logic [2:0]  status_r, status_nxt;
  entry_t      res_r, res_nxt;
  logic [4:0]  max_r;
  logic [31:0] tmo_r;

  logic             we;
  logic [IDX_W-1:0] waddr;
  entry_t           wdata;
  logic [IDX_W-1:0] raddr;
  entry_t           rdata;

  logic [31:0]      lim;
  logic [CNT_W-1:0] live_dec;
  logic [CNT_W-1:0] mv_inc;
  logic             idle_hit;
  logic             key_hit;
  logic             id_hit;
  logic             hit;
  entry_t           upd;
  entry_t           fresh;
  logic             fresh_bound;

  udpfte_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= 5'd16;
      tmo_r <= 32'd30000;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_MAX_ENTRIES) begin
        max_r <= cfg_data[4:0];
      end else begin
        tmo_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      live_r    <= '0;
      next_id_r <= '0;
      shut_r    <= 1'b0;
      evict_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      live_r    <= live_nxt;
      next_id_r <= next_id_nxt;
      shut_r    <= shut_nxt;
      evict_r   <= evict_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    addr_r   <= addr_nxt;
    pp_r     <= pp_nxt;
    qid_r    <= qid_nxt;
    now_r    <= now_nxt;
    open_r   <= open_nxt;
    ps_r     <= ps_nxt;
    idx_r    <= idx_nxt;
    mv_r     <= mv_nxt;
    rev_r    <= rev_nxt;
    status_r <= status_nxt;
    res_r    <= res_nxt;
  end

  assign lim      = (32'(max_r) < 32'(CAPACITY)) ? 32'(max_r) : 32'(CAPACITY);
  assign live_dec = live_r - CNT_W'(1);
  assign mv_inc   = mv_r + CNT_W'(1);
  assign idle_hit = (now_r - rdata.act) >= {32'd0, tmo_r};
  assign key_hit  = (rdata.addr == addr_r) && (rdata.pp == pp_r);
  assign id_hit   = (rdata.id == qid_r);

  always_comb begin
    if (op_r == OP_PURGE || evict_r) begin
      hit = idle_hit;
    end else if (op_r == OP_CLIENT || op_r == OP_FINDKEY) begin
      hit = key_hit;
    end else begin
      hit = id_hit;
    end
  end

  always_comb begin
    upd     = rdata;
    upd.act = now_r;
    if (op_r == OP_REMOTE) begin
      upd.rc = (rdata.rc == 32'hFFFF_FFFF) ? rdata.rc : rdata.rc + 32'd1;
    end else begin
      upd.cc = (rdata.cc == 32'hFFFF_FFFF) ? rdata.cc : rdata.cc + 32'd1;
    end
  end

  always_comb begin
    fresh_bound  = open_r && !shut_r;
    fresh.addr   = addr_r;
    fresh.pp     = pp_r;
    fresh.id     = next_id_r;
    fresh.act    = now_r;
    fresh.cc     = fresh_bound ? 32'd1 : 32'd0;
    fresh.rc     = 32'd0;
    fresh.bound  = fresh_bound;
  end

  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    addr_nxt    = addr_r;
    pp_nxt      = pp_r;
    qid_nxt     = qid_r;
    now_nxt     = now_r;
    open_nxt    = open_r;
    ps_nxt      = ps_r;
    idx_nxt     = idx_r;
    mv_nxt      = mv_r;
    live_nxt    = live_r;
    next_id_nxt = next_id_r;
    shut_nxt    = shut_r;
    evict_nxt   = evict_r;
    rev_nxt     = rev_r;
    status_nxt  = status_r;
    res_nxt     = res_r;
    we          = 1'b0;
    waddr       = idx_r[IDX_W-1:0];
    wdata       = upd;
    raddr       = idx_r[IDX_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt     = in_opcode;
          addr_nxt   = {in_src_addr, in_dst_addr};
          pp_nxt     = {in_src_port, in_dst_port, in_proto_num};
          qid_nxt    = in_id_query;
          now_nxt    = in_now_ms;
          open_nxt   = in_open_ok;
          ps_nxt     = in_partner_status;
          idx_nxt    = '0;
          evict_nxt  = 1'b0;
          rev_nxt    = 1'b0;
          res_nxt    = '0;
          status_nxt = ST_IGNORED;
          case (in_opcode)
            OP_CLIENT: begin
              if (in_proto_num != PROTO_UDP || !in_families_match) begin
                state_nxt = S_DONE;
              end else begin
                state_nxt = S_SRD;
              end
            end
            OP_REMOTE, OP_CLOSE, OP_PURGE, OP_FINDKEY, OP_FINDID: begin
              state_nxt = S_SRD;
            end
            OP_SHUT: begin
              shut_nxt   = 1'b1;
              live_nxt   = '0;
              status_nxt = ST_ACCEPTED;
              state_nxt  = S_DONE;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_SRD: begin
        if (idx_r >= live_r) begin
          state_nxt = S_DONE;
          case (op_r)
            OP_CLIENT: begin
              if (evict_r) begin
                status_nxt = ST_NOCAP;
              end else if (32'(live_r) >= lim) begin
                evict_nxt = 1'b1;
                idx_nxt   = '0;
                state_nxt = S_SRD;
              end else begin
                state_nxt = S_NEW;
              end
            end
            OP_PURGE: begin
              status_nxt = ST_ACCEPTED;
            end
            default: begin
              status_nxt = ST_NOTFOUND;
            end
          endcase
        end else begin
          state_nxt = S_SCHK;
        end
      end
      S_SCHK: begin
        if (!hit) begin
          idx_nxt   = idx_r + CNT_W'(1);
          state_nxt = S_SRD;
        end else begin
          mv_nxt    = idx_r;
          state_nxt = S_DONE;
          case (op_r)
            OP_CLIENT: begin
              if (evict_r) begin
                state_nxt = S_MRD;
              end else if (!rdata.bound) begin
                res_nxt    = rdata;
                status_nxt = ST_REJECTED;
              end else begin
                we      = 1'b1;
                res_nxt = upd;
                case (ps_r)
                  PS_WHOLE:   status_nxt = ST_ACCEPTED;
                  PS_PARTIAL: status_nxt = ST_REJECTED;
                  PS_BLOCK:   status_nxt = ST_BLOCK;
                  default: begin
                    status_nxt = ST_REJECTED;
                    state_nxt  = S_MRD;
                  end
                endcase
              end
            end
            OP_REMOTE: begin
              we         = 1'b1;
              res_nxt    = upd;
              rev_nxt    = 1'b1;
              status_nxt = (ps_r == PS_WHOLE || ps_r == PS_PARTIAL) ? ST_ACCEPTED : ST_BLOCK;
            end
            OP_CLOSE: begin
              res_nxt    = rdata;
              status_nxt = ST_FOUND;
              state_nxt  = S_MRD;
            end
            OP_PURGE: begin
              state_nxt = S_MRD;
            end
            default: begin
              res_nxt    = rdata;
              status_nxt = ST_FOUND;
            end
          endcase
        end
      end
      S_MRD: begin
        raddr = mv_inc[IDX_W-1:0];
        if (mv_inc < live_r) begin
          state_nxt = S_MWR;
        end else begin
          live_nxt  = live_dec;
          state_nxt = S_DONE;
          case (op_r)
            OP_CLIENT: begin
              if (evict_r) begin
                if (32'(live_dec) >= lim) begin
                  status_nxt = ST_NOCAP;
                end else begin
                  state_nxt = S_NEW;
                end
              end
            end
            OP_PURGE: begin
              state_nxt = S_SRD;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_MWR: begin
        we        = 1'b1;
        waddr     = mv_r[IDX_W-1:0];
        wdata     = rdata;
        mv_nxt    = mv_inc;
        state_nxt = S_MRD;
      end
      S_NEW: begin
        we          = 1'b1;
        waddr       = live_r[IDX_W-1:0];
        wdata       = fresh;
        res_nxt     = fresh;
        next_id_nxt = next_id_r + 32'd1;
        live_nxt    = live_r + CNT_W'(1);
        state_nxt   = S_DONE;
        if (!fresh_bound) begin
          status_nxt = ST_REJECTED;
        end else begin
          case (ps_r)
            PS_WHOLE:   status_nxt = ST_ACCEPTED;
            PS_PARTIAL: status_nxt = ST_REJECTED;
            PS_BLOCK:   status_nxt = ST_BLOCK;
            default: begin
              status_nxt = ST_REJECTED;
              live_nxt   = live_r;
            end
          endcase
        end
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy              = (state_r != S_IDLE);
  assign out_valid         = (state_r == S_DONE);
  assign out_status        = status_r;
  assign out_flow_id       = res_r.id;
  assign out_bound         = res_r.bound;
  assign out_last_activity = res_r.act;
  assign out_client_count  = res_r.cc;
  assign out_remote_count  = res_r.rc;
  assign out_src_addr      = rev_r ? res_r.addr[31:0] : res_r.addr[63:32];
  assign out_dst_addr      = rev_r ? res_r.addr[63:32] : res_r.addr[31:0];
  assign out_src_port      = rev_r ? res_r.pp[23:8] : res_r.pp[39:24];
  assign out_dst_port      = rev_r ? res_r.pp[39:24] : res_r.pp[23:8];
  assign out_proto         = res_r.pp[7:0];
  assign out_entry_count   = 5'(live_r);

  `UFT_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy, "accepted item did not raise busy")
  `UFT_ASSERT_NEXT(a_one_result, clk, rst_n, out_valid, !out_valid, "result shown for more than one cycle")
  `UFT_ASSERT_SAME(a_live_bound, clk, rst_n, 1'b1, 32'(live_r) <= 32'(CAPACITY), "live count above capacity")
  `UFT_ASSERT_SAME(a_move_range, clk, rst_n, state_r == S_MWR, mv_inc < live_r, "compaction move past live entries")
endmodule

>>> hw/rtl/udpfte_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module udpfte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
